>>> rtl/jddm_pkg.sv
`default_nettype none
package jddm_pkg;

  // Default angle format: Q1.15 radians.
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 15;

  // Each centered axis is pre-scaled by this shift before the rotations.
  localparam int unsigned PRESHIFT = 24;
  // Width of the rotation datapath (holds 1.65 * sqrt(2) * 511 * 2^24, signed).
  localparam int unsigned CORDIC_W = 37;
  localparam int unsigned ATAN_ENTRIES = 24;

  // Integer square root of a 20-bit sum: ten result digits.
  localparam int unsigned SQ_W     = 20;
  localparam int unsigned SQ_STEPS = 10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN   = 3'd4;

  localparam logic [11:0] CENTER_VALUE_RST = 12'd1500;
  localparam logic [8:0]  DEAD_ZONE_RST    = 9'd50;
  localparam logic [7:0]  RIGHT_OFFSET_RST = 8'd20;
  localparam logic [7:0]  LEFT_OFFSET_RST  = 8'd20;
  localparam logic [7:0]  ANGLE_GAIN_RST   = 8'd127;

  // Quadrant LED codes.
  localparam logic [2:0] LED_NONE = 3'd0;
  localparam logic [2:0] LED_Q1   = 3'd1;
  localparam logic [2:0] LED_Q2   = 3'd2;
  localparam logic [2:0] LED_Q3   = 3'd3;
  localparam logic [2:0] LED_Q4   = 3'd4;

  // atan(2^-i) in Q2.30.
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // Table entry rescaled to f fraction bits, rounding half up.
  function automatic logic [31:0] atan_entry(input int unsigned i, input int unsigned f);
    logic [63:0] t;
    t = 64'(ATAN_Q30[i % ATAN_ENTRIES]) + (64'd1 << (29 - f));
    return 32'(t >> (30 - f));
  endfunction

endpackage
`default_nettype wire

>>> rtl/joystick_differential_drive_mixer_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_raw_x, in_raw_y (12 bits each)
// out_    | output    | out_valid/out_stall| motor A/B reverse and speed, quadrant LED
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index (3 bits), cfg_data (12 bits)
//
// A request accepted at the input passes stages 0 and 1, the rotation stages, the scaling
// stage and the output register to out_valid; one request enters per cycle unless stalled.
// The depth is set by the rotation pipeline: one angle iteration per stage, ANGLE_FRAC_BITS+1.
// The square root digits share those stages and finish well before the last rotation.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads register defaults.
// The whole pipeline holds while the output register is full and stalled; nothing is dropped.
`default_nettype none
module joystick_differential_drive_mixer_core #(
  parameter int unsigned ANGLE_FRAC_BITS = jddm_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_raw_x,
  input  wire logic [11:0] in_raw_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_motor_a_reverse,
  output logic [7:0]       out_motor_a_speed,
  output logic             out_motor_b_reverse,
  output logic [7:0]       out_motor_b_speed,
  output logic [2:0]       out_quadrant_led,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jddm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned F  = ANGLE_FRAC_BITS;
  localparam int unsigned NI = F + 1;            // rotation iterations
  localparam int unsigned CW = jddm_pkg::CORDIC_W;
  localparam int unsigned ZW = F + 3;            // signed angle accumulator
  localparam int unsigned SW = jddm_pkg::SQ_W;
  localparam logic [ZW-1:0] QUARTER_PI = ZW'(jddm_pkg::atan_entry(0, F));

  // Configuration registers. Write only while the pipeline is empty; the block does not enforce it.
  logic [11:0] center_r;
  logic [8:0]  dead_zone_r;
  logic [7:0]  right_off_r;
  logic [7:0]  left_off_r;
  logic [7:0]  gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= jddm_pkg::CENTER_VALUE_RST;
      dead_zone_r <= jddm_pkg::DEAD_ZONE_RST;
      right_off_r <= jddm_pkg::RIGHT_OFFSET_RST;
      left_off_r  <= jddm_pkg::LEFT_OFFSET_RST;
      gain_r      <= jddm_pkg::ANGLE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jddm_pkg::REG_CENTER_VALUE: center_r    <= cfg_data;
        jddm_pkg::REG_DEAD_ZONE:    dead_zone_r <= cfg_data[8:0];
        jddm_pkg::REG_RIGHT_OFFSET: right_off_r <= cfg_data[7:0];
        jddm_pkg::REG_LEFT_OFFSET:  left_off_r  <= cfg_data[7:0];
        jddm_pkg::REG_ANGLE_GAIN:   gain_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Every stage moves together unless a finished result is waiting on a stall.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 0: center each axis and divide by 8, truncating toward zero.
  logic signed [12:0] dx, dy, dqx, dqy;
  logic               v0_r;
  logic signed [9:0]  x0_r, y0_r;

  always_comb begin
    dx  = $signed({1'b0, in_raw_x}) - $signed({1'b0, center_r});
    dy  = $signed({1'b0, in_raw_y}) - $signed({1'b0, center_r});
    dqx = dx + (dx[12] ? 13'sd7 : 13'sd0);
    dqy = dy + (dy[12] ? 13'sd7 : 13'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= dqx[12:3];
      y0_r <= dqy[12:3];
    end
  end

  // Stage 1: absolute values and their squares.
  logic [8:0]        ax0, ay0;
  logic              v1_r;
  logic [8:0]        ax1_r, ay1_r;
  logic [17:0]       sqx1_r, sqy1_r;
  logic signed [9:0] x1_r, y1_r;

  assign ax0 = x0_r[9] ? 9'(-x0_r) : x0_r[8:0];
  assign ay0 = y0_r[9] ? 9'(-y0_r) : y0_r[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r  <= ax0;
      ay1_r  <= ay0;
      sqx1_r <= ax0 * ax0;
      sqy1_r <= ay0 * ay0;
      x1_r   <= x0_r;
      y1_r   <= y0_r;
    end
  end

  // Iteration stages. Entry k holds the state that iteration k consumes:
  // the vector (px, py), the angle sum pz, and the square root remainder
  // pv with partial root pr.
  logic                 pvld_r [NI+1];
  logic signed [CW-1:0] px_r   [NI+1];
  logic signed [CW-1:0] py_r   [NI+1];
  logic signed [ZW-1:0] pz_r   [NI+1];
  logic [SW-1:0]        pv_r   [NI+1];
  logic [SW-1:0]        pr_r   [NI+1];
  logic signed [9:0]    pcx_r  [NI+1];
  logic signed [9:0]    pcy_r  [NI+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r[0] <= 1'b0;
    end else if (adv) begin
      pvld_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0]  <= CW'(ax1_r) << jddm_pkg::PRESHIFT;
      py_r[0]  <= CW'(ay1_r) << jddm_pkg::PRESHIFT;
      pz_r[0]  <= '0;
      pv_r[0]  <= SW'(sqx1_r) + SW'(sqy1_r);
      pr_r[0]  <= '0;
      pcx_r[0] <= x1_r;
      pcy_r[0] <= y1_r;
    end
  end

  for (genvar k = 0; k < NI; k++) begin : g_iter
    localparam logic [ZW-1:0] ATAN_K = ZW'(jddm_pkg::atan_entry(k, F));
    localparam logic [SW-1:0] SQ_BIT =
      (k < jddm_pkg::SQ_STEPS) ? (SW'(1) << (2 * (jddm_pkg::SQ_STEPS - 1 - k))) : '0;

    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;
    logic [SW:0]          trial;
    logic [SW-1:0]        v_nxt, r_nxt;

    always_comb begin
      xs    = px_r[k] >>> k;
      ys    = py_r[k] >>> k;
      x_nxt = px_r[k];
      y_nxt = py_r[k];
      z_nxt = pz_r[k];
      if (py_r[k] > 0) begin
        x_nxt = px_r[k] + ys;
        y_nxt = py_r[k] - xs;
        z_nxt = pz_r[k] + $signed(ATAN_K);
      end else if (py_r[k] < 0) begin
        x_nxt = px_r[k] - ys;
        y_nxt = py_r[k] + xs;
        z_nxt = pz_r[k] - $signed(ATAN_K);
      end
    end

    // One digit of the restoring square root; later stages pass it through.
    always_comb begin
      trial = (SW+1)'(pr_r[k]) + (SW+1)'(SQ_BIT);
      v_nxt = pv_r[k];
      r_nxt = pr_r[k];
      if (SQ_BIT != '0) begin
        if ((SW+1)'(pv_r[k]) >= trial) begin
          v_nxt = pv_r[k] - trial[SW-1:0];
          r_nxt = (pr_r[k] >> 1) + SQ_BIT;
        end else begin
          r_nxt = pr_r[k] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pvld_r[k+1] <= 1'b0;
      end else if (adv) begin
        pvld_r[k+1] <= pvld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        px_r[k+1]  <= x_nxt;
        py_r[k+1]  <= y_nxt;
        pz_r[k+1]  <= z_nxt;
        pv_r[k+1]  <= v_nxt;
        pr_r[k+1]  <= r_nxt;
        pcx_r[k+1] <= pcx_r[k];
        pcy_r[k+1] <= pcy_r[k];
      end
    end
  end

  // Scaling stage: distance of the clamped angle from pi/4 times the gain,
  // and the offset magnitude.
  logic [ZW-1:0]      zc, ang_dist;
  logic               below;
  logic [ZW+7:0]      prod;
  logic               vm_r, below_r;
  logic [10:0]        base_r, mag_r;
  logic signed [9:0]  xm_r, ym_r;

  always_comb begin
    zc       = pz_r[NI][ZW-1] ? '0 : pz_r[NI];
    below    = zc < QUARTER_PI;
    ang_dist = below ? (QUARTER_PI - zc) : (zc - QUARTER_PI);
    prod     = (ZW+8)'(ang_dist) * (ZW+8)'(gain_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= pvld_r[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      below_r <= below;
      base_r  <= 11'(prod >> F);
      mag_r   <= 11'(pr_r[NI]) + 11'(right_off_r);
      xm_r    <= pcx_r[NI];
      ym_r    <= pcy_r[NI];
    end
  end

  // Output stage: saturate and mix into the two motor commands.
  logic [11:0] sr_w, sl_w;
  logic [7:0]  m_sat, sr_sat, sl_sat;
  logic        a_rev_nxt, b_rev_nxt;
  logic [7:0]  a_spd_nxt, b_spd_nxt;
  logic [2:0]  led_nxt;
  logic        x_pos, x_neg, y_pos, y_neg;

  always_comb begin
    sr_w   = 12'(base_r) + 12'(right_off_r);
    sl_w   = 12'(base_r) + 12'(left_off_r);
    m_sat  = (mag_r > 11'd255) ? 8'd255 : mag_r[7:0];
    sr_sat = (sr_w > 12'd255) ? 8'd255 : sr_w[7:0];
    sl_sat = (sl_w > 12'd255) ? 8'd255 : sl_w[7:0];
    x_neg  = xm_r[9];
    y_neg  = ym_r[9];
    x_pos  = !x_neg && (xm_r != '0);
    y_pos  = !y_neg && (ym_r != '0);

    a_rev_nxt = 1'b0;
    b_rev_nxt = 1'b0;
    a_spd_nxt = '0;
    b_spd_nxt = '0;
    led_nxt   = jddm_pkg::LED_NONE;

    if ((mag_r < 11'(dead_zone_r)) || (!x_pos && !x_neg && !y_pos && !y_neg)) begin
      // Stopped: defaults hold.
    end else if (!x_pos && !x_neg) begin
      a_rev_nxt = !y_pos;
      b_rev_nxt = !y_pos;
      a_spd_nxt = m_sat;
      b_spd_nxt = m_sat;
    end else if (!y_pos && !y_neg) begin
      a_rev_nxt = x_pos;
      b_rev_nxt = !x_pos;
      a_spd_nxt = m_sat;
      b_spd_nxt = m_sat;
    end else if (x_pos && y_pos) begin
      led_nxt   = jddm_pkg::LED_Q1;
      a_rev_nxt = below_r;
      a_spd_nxt = sr_sat;
      b_spd_nxt = m_sat;
    end else if (x_neg && y_pos) begin
      led_nxt   = jddm_pkg::LED_Q2;
      a_spd_nxt = m_sat;
      b_rev_nxt = below_r;
      b_spd_nxt = sl_sat;
    end else if (x_neg) begin
      led_nxt   = jddm_pkg::LED_Q3;
      a_rev_nxt = !below_r;
      a_spd_nxt = sr_sat;
      b_rev_nxt = 1'b1;
      b_spd_nxt = m_sat;
    end else begin
      // Fourth quadrant: motor B's direction follows which side of pi/4 the angle lies on.
      led_nxt   = jddm_pkg::LED_Q4;
      a_rev_nxt = 1'b1;
      a_spd_nxt = m_sat;
      b_rev_nxt = !below_r;
      b_spd_nxt = sl_sat;
    end
  end

  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_motor_a_reverse <= a_rev_nxt;
      out_motor_a_speed   <= a_spd_nxt;
      out_motor_b_reverse <= b_rev_nxt;
      out_motor_b_speed   <= b_spd_nxt;
      out_quadrant_led    <= led_nxt;
    end
  end

  // An accepted request always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v0_r)
    else $error("accepted request lost at stage 0");

  // A held pipeline keeps its scaling-stage valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |=> $stable(vm_r))
    else $error("pipeline moved while stalled");

  // Without a lit quadrant both motors run at the same level.
  a_no_led_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_quadrant_led == jddm_pkg::LED_NONE)
      |-> (out_motor_a_speed == out_motor_b_speed))
    else $error("unequal speeds without quadrant");

  // First quadrant keeps motor B forward.
  a_q1_b_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_quadrant_led == jddm_pkg::LED_Q1) |-> !out_motor_b_reverse)
    else $error("quadrant one motor B reversed");

endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;

  // One motor command as the mixer returns it for one stick sample.
  typedef struct packed {
    logic       a_rev;
    logic [7:0] a_spd;
    logic       b_rev;
    logic [7:0] b_spd;
    logic [2:0] led;
  } motor_cmd_t;

  typedef struct packed {
    logic [11:0] rx;
    logic [11:0] ry;
  } stick_sample_t;

  localparam int FRAC = jddm_pkg::ANGLE_FRAC_BITS_DEF;
  // Cycles to let the pipeline drain before a register write.
  localparam int DRAIN_CYCLES = 40;

  // Arctangent of 2^-i in Q2.30, one entry per rotation of the vectoring loop.
  localparam longint ARC_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_raw_x = '0;
  logic [11:0] in_raw_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_motor_a_reverse;
  logic [7:0]  out_motor_a_speed;
  logic        out_motor_b_reverse;
  logic [7:0]  out_motor_b_speed;
  logic [2:0]  out_quadrant_led;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jddm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  joystick_differential_drive_mixer_core dut (.*);

  // The testbench's own copy of the mixer's registers.
  logic [11:0] center_q = jddm_pkg::CENTER_VALUE_RST;
  logic [8:0]  dead_zone_q = jddm_pkg::DEAD_ZONE_RST;
  logic [7:0]  right_off_q = jddm_pkg::RIGHT_OFFSET_RST;
  logic [7:0]  left_off_q = jddm_pkg::LEFT_OFFSET_RST;
  logic [7:0]  gain_q = jddm_pkg::ANGLE_GAIN_RST;

  stick_sample_t samples_to_send[$];
  motor_cmd_t    expected_cmds[$];
  logic          sample_taken = 1'b0;
  bit            jitter_on = 1'b1;
  int            mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Computes the motor command for one sample from the current register copy.
  // The angle comes from a CORDIC vectoring loop in fixed point; all shifts
  // on signed values floor, which the arithmetic shift gives directly.
  function automatic motor_cmd_t mix_sample(input logic [11:0] rx, input logic [11:0] ry);
    int          x, y, ax, ay;
    int unsigned sum, root, bitv, mag, m_sat, sr, sl;
    longint      vx, vy, vz, xs, ys, arc, q, ang_dist, base;
    bit          below;
    motor_cmd_t  c;
    c = '0;
    x = (int'(rx) - int'(center_q)) / 8;
    y = (int'(ry) - int'(center_q)) / 8;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    // Digit-by-digit integer square root.
    sum = ax * ax + ay * ay;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > sum) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sum >= root + bitv) begin
        sum = sum - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    mag = root + right_off_q;
    m_sat = (mag > 255) ? 255 : mag;
    if (mag < dead_zone_q || (x == 0 && y == 0)) begin
      // Stopped: everything stays zero.
    end else if (x == 0) begin
      c.a_rev = (y > 0) ? 1'b0 : 1'b1;
      c.b_rev = c.a_rev;
      c.a_spd = m_sat[7:0];
      c.b_spd = m_sat[7:0];
    end else if (y == 0) begin
      c.a_rev = (x > 0);
      c.b_rev = (x < 0);
      c.a_spd = m_sat[7:0];
      c.b_spd = m_sat[7:0];
    end else begin
      vx = longint'(ax) <<< 24;
      vy = longint'(ay) <<< 24;
      vz = 0;
      q = (ARC_Q30[0] + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      for (int i = 0; i <= FRAC; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        arc = (ARC_Q30[i] + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        if (vy > 0) begin
          vx = vx + ys;
          vy = vy - xs;
          vz = vz + arc;
        end else if (vy < 0) begin
          vx = vx - ys;
          vy = vy + xs;
          vz = vz - arc;
        end
      end
      if (vz < 0) vz = 0;
      below = (vz < q);
      ang_dist = below ? (q - vz) : (vz - q);
      base = (ang_dist * longint'(gain_q)) >>> FRAC;
      sr = (base + right_off_q > 255) ? 255 : int'(base) + right_off_q;
      sl = (base + left_off_q > 255) ? 255 : int'(base) + left_off_q;
      if (x > 0 && y > 0) begin
        c.led = jddm_pkg::LED_Q1; c.a_rev = below; c.a_spd = sr[7:0];
        c.b_rev = 1'b0; c.b_spd = m_sat[7:0];
      end else if (x < 0 && y > 0) begin
        c.led = jddm_pkg::LED_Q2; c.a_rev = 1'b0; c.a_spd = m_sat[7:0];
        c.b_rev = below; c.b_spd = sl[7:0];
      end else if (x < 0) begin
        c.led = jddm_pkg::LED_Q3; c.a_rev = !below; c.a_spd = sr[7:0];
        c.b_rev = 1'b1; c.b_spd = m_sat[7:0];
      end else begin
        c.led = jddm_pkg::LED_Q4; c.a_rev = 1'b1; c.a_spd = m_sat[7:0];
        c.b_rev = !below; c.b_spd = sl[7:0];
      end
    end
    return c;
  endfunction

  // Request driver. A new request is presented only once the previous one has
  // been taken, so a stalled request never changes. With jitter on, each chance
  // to send a request is skipped on purpose with probability 0.28.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || sample_taken)) begin
      if (samples_to_send.size() > 0 && !(jitter_on && $urandom_range(99) < 28)) begin
        stick_sample_t s;
        s = samples_to_send.pop_front();
        in_valid <= 1'b1;
        in_raw_x <= s.rx;
        in_raw_y <= s.ry;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // The result side stalls at the same rate, and never in the quiet stretch.
    out_stall <= jitter_on && ($urandom_range(99) < 28);
  end

  // An accepted request gets its predicted command queued right away, using
  // the register copy that is in force, since writes happen only while idle.
  always @(posedge clk) begin
    sample_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_cmds.push_back(mix_sample(in_raw_x, in_raw_y));
    end
  end

  // Result monitor: each accepted result is checked field by field against
  // the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        motor_cmd_t e;
        e = expected_cmds.pop_front();
        if (out_motor_a_reverse !== e.a_rev) begin
          $error("motor_a_reverse: expected %0d, got %0d", e.a_rev, out_motor_a_reverse);
          mismatches++;
        end
        if (out_motor_a_speed !== e.a_spd) begin
          $error("motor_a_speed: expected %0d, got %0d", e.a_spd, out_motor_a_speed);
          mismatches++;
        end
        if (out_motor_b_reverse !== e.b_rev) begin
          $error("motor_b_reverse: expected %0d, got %0d", e.b_rev, out_motor_b_reverse);
          mismatches++;
        end
        if (out_motor_b_speed !== e.b_spd) begin
          $error("motor_b_speed: expected %0d, got %0d", e.b_spd, out_motor_b_speed);
          mismatches++;
        end
        if (out_quadrant_led !== e.led) begin
          $error("quadrant_led: expected %0d, got %0d", e.led, out_quadrant_led);
          mismatches++;
        end
      end
    end
  end

  // Queues a sample given as centered deflections from the current center.
  task automatic push_deflection(input int dx, input int dy);
    stick_sample_t s;
    int rx, ry;
    rx = int'(center_q) + 8 * dx;
    ry = int'(center_q) + 8 * dy;
    rx = (rx < 0) ? 0 : (rx > 4095) ? 4095 : rx;
    ry = (ry < 0) ? 0 : (ry > 4095) ? 4095 : ry;
    s.rx = rx[11:0];
    s.ry = ry[11:0];
    samples_to_send.push_back(s);
  endtask

  // Waits until every queued request has gone in and every result came back,
  // then lets the pipeline run dry before any register is touched.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (samples_to_send.size() != 0 || in_valid || expected_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write on the configuration port. The local copy follows the
  // same masking the hardware applies; unknown indexes change nothing.
  task automatic write_reg(input logic [jddm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jddm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jddm_pkg::REG_CENTER_VALUE: center_q = val;
      jddm_pkg::REG_DEAD_ZONE:    dead_zone_q = val[8:0];
      jddm_pkg::REG_RIGHT_OFFSET: right_off_q = val[7:0];
      jddm_pkg::REG_LEFT_OFFSET:  left_off_q = val[7:0];
      jddm_pkg::REG_ANGLE_GAIN:   gain_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: half the samples are real deflections around the center, a
  // share are small ones near the dead zone, and the rest are raw values over
  // the whole 12-bit range.
  task automatic push_random(input int count);
    stick_sample_t s;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          s.rx = $urandom_range(4095);
          s.ry = $urandom_range(4095);
          samples_to_send.push_back(s);
        end
        3, 4: push_deflection(int'($urandom_range(20)) - 10, int'($urandom_range(20)) - 10);
        5: push_deflection(0, int'($urandom_range(1022)) - 511);
        6: push_deflection(int'($urandom_range(1022)) - 511, 0);
        default: push_deflection(int'($urandom_range(1022)) - 511,
                                 int'($urandom_range(1022)) - 511);
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples at reset values: the dead zone, a centered stick, the
    // truncation of small offsets to zero, both axes in both directions, each
    // quadrant on both sides of the diagonal, and the raw extremes.
    jitter_on = 1'b1;
    push_deflection(1, 1);
    push_deflection(0, 0);
    samples_to_send.push_back('{rx: 12'd1507, ry: 12'd1493});
    push_deflection(0, 200);
    push_deflection(0, -200);
    push_deflection(200, 0);
    push_deflection(-200, 0);
    push_deflection(100, 99);
    push_deflection(99, 100);
    push_deflection(-100, 99);
    push_deflection(-99, 100);
    push_deflection(-100, -99);
    push_deflection(-99, -100);
    push_deflection(100, -99);
    push_deflection(99, -100);
    push_deflection(300, 5);
    push_deflection(-5, -300);
    samples_to_send.push_back('{rx: 12'd0, ry: 12'd0});
    samples_to_send.push_back('{rx: 12'd4095, ry: 12'd4095});
    samples_to_send.push_back('{rx: 12'd0, ry: 12'd4095});
    samples_to_send.push_back('{rx: 12'd4095, ry: 12'd0});
    push_random(110);
    wait_idle();

    // Extremes: no dead zone, full offsets and gain, center at the bottom.
    write_reg(jddm_pkg::REG_CENTER_VALUE, 12'd0);
    write_reg(jddm_pkg::REG_DEAD_ZONE, 12'd0);
    write_reg(jddm_pkg::REG_RIGHT_OFFSET, 12'd255);
    write_reg(jddm_pkg::REG_LEFT_OFFSET, 12'd255);
    write_reg(jddm_pkg::REG_ANGLE_GAIN, 12'd255);
    push_deflection(0, 0);
    push_random(110);
    wait_idle();

    // Opposite extremes, with oversized data that the hardware must mask.
    write_reg(jddm_pkg::REG_CENTER_VALUE, 12'd4095);
    write_reg(jddm_pkg::REG_DEAD_ZONE, 12'hFFF);
    write_reg(jddm_pkg::REG_RIGHT_OFFSET, 12'hF00);
    write_reg(jddm_pkg::REG_LEFT_OFFSET, 12'hF00);
    write_reg(jddm_pkg::REG_ANGLE_GAIN, 12'hF00);
    push_random(110);
    wait_idle();

    // Center in the middle, zero dead zone and offsets; writes to unused
    // indexes must leave every register alone. This stretch runs without idling.
    jitter_on = 1'b0;
    write_reg(jddm_pkg::REG_CENTER_VALUE, 12'd2048);
    write_reg(jddm_pkg::REG_DEAD_ZONE, 12'd0);
    write_reg(jddm_pkg::REG_RIGHT_OFFSET, 12'd0);
    write_reg(jddm_pkg::REG_LEFT_OFFSET, 12'd0);
    write_reg(jddm_pkg::REG_ANGLE_GAIN, 12'd255);
    write_reg(3'd5, 12'hFFF);
    write_reg(3'd6, 12'hAAA);
    write_reg(3'd7, 12'h555);
    push_deflection(0, 0);
    push_deflection(100, 99);
    push_deflection(-99, -100);
    push_random(150);
    wait_idle();
    jitter_on = 1'b1;

    // A few random settings to finish.
    for (int p = 0; p < 3; p++) begin
      write_reg(jddm_pkg::REG_CENTER_VALUE, 12'(1000 + $urandom_range(2000)));
      write_reg(jddm_pkg::REG_DEAD_ZONE, 12'($urandom_range(4095)));
      write_reg(jddm_pkg::REG_RIGHT_OFFSET, 12'($urandom_range(4095)));
      write_reg(jddm_pkg::REG_LEFT_OFFSET, 12'($urandom_range(4095)));
      write_reg(jddm_pkg::REG_ANGLE_GAIN, 12'($urandom_range(4095)));
      push_random(100);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of 805 requests.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
